// File: rtl/jnv_pkg.sv
// jnv_pkg: shared types and constants of the JSON nesting validator.
// Used by jnv_front, jnv_queue, jnv_back and json_nesting_validator.
// No dependencies.
package jnv_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_NL      = 8'h0a;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_LBRACK  = 8'h5b;
	localparam logic [7:0] CH_RBRACK  = 8'h5d;
	localparam logic [7:0] CH_LBRACE  = 8'h7b;
	localparam logic [7:0] CH_RBRACE  = 8'h7d;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_COLON   = 8'h3a;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_STRING  = 2'd2,
		MODE_ESCAPE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CTX_SCALAR = 2'd0,
		CTX_ARRAY  = 2'd1,
		CTX_KEY    = 2'd2,
		CTX_VALUE  = 2'd3
	} ctx_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_OVERFLOW  = 3'd1,
		ERR_UNDERFLOW = 3'd2,
		ERR_SEPARATOR = 3'd3,
		ERR_UNCLOSED  = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		OP_NOP      = 3'd0,
		OP_PUSH_ARR = 3'd1,
		OP_PUSH_KEY = 3'd2,
		OP_POP      = 3'd3,
		OP_COMMA    = 3'd4,
		OP_COLON    = 3'd5
	} op_t;

	typedef struct packed {
		op_t  op;
		logic last;
	} op_item_t;

endpackage

// File: rtl/json_nesting_validator.sv
// json_nesting_validator: one byte per cycle while the queue has room; the last byte
// is registered in the queue at the accepting edge, its verdict in the output register.
// Throughput: 1 byte per cycle, set by the stack engine, which stalls a last byte while a
// verdict waits; it pops from a memory with a registered read of the entry below the top.
// Reset (arst_n low): lexer mode, queue, stack pointer and error clear at once;
// the stack memory is not cleared, every entry is pushed before it is read.
module json_nesting_validator #(
	parameter int STACK_DEPTH = jnv_pkg::STACK_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       valid_res,
	output logic [2:0] error_code
);

	logic              fq_valid, fq_ready, qb_valid, qb_ready;
	jnv_pkg::op_item_t fq_item, qb_item;

	jnv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last      (last),
		.q_ready   (fq_ready),
		.q_valid   (fq_valid),
		.q_item    (fq_item)
	);

	jnv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	jnv_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (qb_valid),
		.op_ready   (qb_ready),
		.op_item    (qb_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.valid_res  (valid_res),
		.error_code (error_code)
	);

	a_verdict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (valid_res == (error_code == jnv_pkg::ERR_NONE)))
		else $error("verdict flag disagrees with error code");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code <= jnv_pkg::ERR_UNCLOSED))
		else $error("error code out of range");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> qb_valid)
		else $error("queue refuses bytes while empty");

	a_verdict_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		(qb_valid && qb_ready && qb_item.last) |=> out_valid)
		else $error("last byte processed without a verdict");

endmodule

// File: rtl/jnv_front.sv
// jnv_front: lexer of the validator. Tracks comment and string modes and
// turns each accepted byte into a structural op for the back end.
// Depends on jnv_pkg.
module jnv_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last,
	input  logic               q_ready,
	output logic               q_valid,
	output jnv_pkg::op_item_t  q_item
);

	jnv_pkg::mode_t mode_q, mode_nxt;
	logic           quote_q, quote_nxt;
	jnv_pkg::op_t   op;
	logic           fire;

	assign in_ready = q_ready;
	assign fire     = in_valid & q_ready;
	assign q_valid  = in_valid;
	assign q_item   = '{op: op, last: last};

	always_comb begin
		mode_nxt  = mode_q;
		quote_nxt = quote_q;
		op        = jnv_pkg::OP_NOP;
		unique case (mode_q)
			jnv_pkg::MODE_COMMENT: begin
				if (data_byte == jnv_pkg::CH_NL) mode_nxt = jnv_pkg::MODE_NORMAL;
			end
			jnv_pkg::MODE_ESCAPE: begin
				mode_nxt = jnv_pkg::MODE_STRING;
			end
			jnv_pkg::MODE_STRING: begin
				if (data_byte == (quote_q ? jnv_pkg::CH_SQUOTE : jnv_pkg::CH_DQUOTE))
					mode_nxt = jnv_pkg::MODE_NORMAL;
				else if (data_byte == jnv_pkg::CH_BSLASH)
					mode_nxt = jnv_pkg::MODE_ESCAPE;
			end
			jnv_pkg::MODE_NORMAL: begin
				// after an error the back end drops every op, so mode changes
				// seen here past that point cannot affect the verdict
				unique case (data_byte)
					jnv_pkg::CH_HASH:   mode_nxt = jnv_pkg::MODE_COMMENT;
					jnv_pkg::CH_DQUOTE: begin
						mode_nxt  = jnv_pkg::MODE_STRING;
						quote_nxt = 1'b0;
					end
					jnv_pkg::CH_SQUOTE: begin
						mode_nxt  = jnv_pkg::MODE_STRING;
						quote_nxt = 1'b1;
					end
					jnv_pkg::CH_LBRACK: op = jnv_pkg::OP_PUSH_ARR;
					jnv_pkg::CH_LBRACE: op = jnv_pkg::OP_PUSH_KEY;
					jnv_pkg::CH_RBRACK,
					jnv_pkg::CH_RBRACE: op = jnv_pkg::OP_POP;
					jnv_pkg::CH_COMMA:  op = jnv_pkg::OP_COMMA;
					jnv_pkg::CH_COLON:  op = jnv_pkg::OP_COLON;
					default:            op = jnv_pkg::OP_NOP;
				endcase
			end
			default: mode_nxt = jnv_pkg::MODE_NORMAL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= jnv_pkg::MODE_NORMAL;
			quote_q <= 1'b0;
		end else if (fire) begin
			if (last) begin
				mode_q  <= jnv_pkg::MODE_NORMAL;
				quote_q <= 1'b0;
			end else begin
				mode_q  <= mode_nxt;
				quote_q <= quote_nxt;
			end
		end
	end

endmodule

// File: rtl/jnv_queue.sv
// jnv_queue: short FIFO of ops between the lexer and the stack engine.
// Depends on jnv_pkg.
module jnv_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  jnv_pkg::op_item_t  push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output jnv_pkg::op_item_t  pop_item
);

	localparam int PW = $clog2(jnv_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(jnv_pkg::QUEUE_DEPTH + 1);

	jnv_pkg::op_item_t slot_q [jnv_pkg::QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != CW'(jnv_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(jnv_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

// File: rtl/jnv_back.sv
// jnv_back: stack engine. Applies ops to the context stack, tracks the
// first error and registers the verdict on the last byte.
// Depends on jnv_pkg.
module jnv_back #(
	parameter int STACK_DEPTH = jnv_pkg::STACK_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  jnv_pkg::op_item_t  op_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               valid_res,
	output logic [2:0]         error_code
);

	localparam int SP_W = $clog2(STACK_DEPTH);

	// top of stack lives in top_q; entries below it live in the memory,
	// with the one just under the top prefetched into below_q
	jnv_pkg::ctx_t stack_mem [STACK_DEPTH-1];

	logic [SP_W-1:0] sp_q, sp_nxt, sp_new;
	jnv_pkg::ctx_t   top_q, top_nxt, below_q;
	jnv_pkg::err_t   err_q, err_nxt, code;
	logic            push_en, fire;
	logic            out_valid_q, valid_res_q;
	logic [2:0]      error_code_q;

	assign op_ready = !op_item.last || !out_valid_q || out_ready;
	assign fire     = op_valid & op_ready;

	always_comb begin
		sp_nxt  = sp_q;
		top_nxt = top_q;
		err_nxt = err_q;
		push_en = 1'b0;
		if (err_q == jnv_pkg::ERR_NONE) begin
			unique case (op_item.op)
				jnv_pkg::OP_PUSH_ARR,
				jnv_pkg::OP_PUSH_KEY: begin
					if (sp_q == SP_W'(STACK_DEPTH - 1)) begin
						err_nxt = jnv_pkg::ERR_OVERFLOW;
					end else begin
						push_en = 1'b1;
						sp_nxt  = sp_q + SP_W'(1);
						top_nxt = (op_item.op == jnv_pkg::OP_PUSH_ARR) ?
							jnv_pkg::CTX_ARRAY : jnv_pkg::CTX_KEY;
					end
				end
				jnv_pkg::OP_POP: begin
					if (sp_q == '0) begin
						err_nxt = jnv_pkg::ERR_UNDERFLOW;
					end else begin
						sp_nxt  = sp_q - SP_W'(1);
						top_nxt = below_q;
					end
				end
				jnv_pkg::OP_COMMA: begin
					if (top_q == jnv_pkg::CTX_VALUE)      top_nxt = jnv_pkg::CTX_KEY;
					else if (top_q != jnv_pkg::CTX_ARRAY) err_nxt = jnv_pkg::ERR_SEPARATOR;
				end
				jnv_pkg::OP_COLON: begin
					if (top_q == jnv_pkg::CTX_KEY) top_nxt = jnv_pkg::CTX_VALUE;
					else                           err_nxt = jnv_pkg::ERR_SEPARATOR;
				end
				default: ;
			endcase
		end
		priority if (err_nxt != jnv_pkg::ERR_NONE) code = err_nxt;
		else if (sp_nxt != '0)                    code = jnv_pkg::ERR_UNCLOSED;
		else                                      code = jnv_pkg::ERR_NONE;
		sp_new = op_item.last ? '0 : sp_nxt;
	end

	// stack memory: either one write or one registered read per cycle; a push
	// forwards the old top, which is exactly the new entry under the top
	always_ff @(posedge clk) begin
		if (fire && push_en) begin
			stack_mem[sp_q] <= top_q;
			below_q         <= top_q;
		end else if (fire && op_item.op == jnv_pkg::OP_POP && sp_new != '0) begin
			below_q <= stack_mem[sp_new - SP_W'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			top_q <= jnv_pkg::CTX_SCALAR;
			err_q <= jnv_pkg::ERR_NONE;
		end else if (fire) begin
			if (op_item.last) begin
				sp_q  <= '0;
				top_q <= jnv_pkg::CTX_SCALAR;
				err_q <= jnv_pkg::ERR_NONE;
			end else begin
				sp_q  <= sp_nxt;
				top_q <= top_nxt;
				err_q <= err_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && op_item.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && op_item.last) begin
			valid_res_q  <= code == jnv_pkg::ERR_NONE;
			error_code_q <= code;
		end
	end

	assign out_valid  = out_valid_q;
	assign valid_res  = valid_res_q;
	assign error_code = error_code_q;

endmodule

// File: bench/verdict_checker.sv
// verdict_checker: watches the byte and verdict channels of json_nesting_validator,
// predicts each verdict from the accepted bytes and compares it field by field.
// Depends on jnv_pkg.
module verdict_checker
	import jnv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       valid_res,
	input  logic [2:0] error_code,
	output int         failures,
	output int         pending
);

	typedef struct {
		logic ok;
		err_t code;
	} verdict_t;

	verdict_t    verdicts_due[$];

	// predicted document state
	mode_t       lex;
	logic        single_q;
	ctx_t        nest_ctx[STACK_DEPTH];
	int unsigned depth;
	err_t        first_err;

	task automatic clear_document();
		lex = MODE_NORMAL;
		single_q = 1'b0;
		nest_ctx[0] = CTX_SCALAR;
		depth = 0;
		first_err = ERR_NONE;
	endtask

	task automatic report_mismatch(input string what);
		if (failures < 100)
			$display("MISMATCH at %0t: %s", $time, what);
		failures++;
	endtask

	task automatic push_ctx(input ctx_t c);
		if (depth + 1 >= STACK_DEPTH) begin
			first_err = ERR_OVERFLOW;
		end else begin
			depth++;
			nest_ctx[depth] = c;
		end
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		ctx_t top;
		case (lex)
			MODE_COMMENT: begin
				if (b == CH_NL)
					lex = MODE_NORMAL;
			end
			MODE_ESCAPE: lex = MODE_STRING;
			MODE_STRING: begin
				if (b == (single_q ? CH_SQUOTE : CH_DQUOTE))
					lex = MODE_NORMAL;
				else if (b == CH_BSLASH)
					lex = MODE_ESCAPE;
			end
			default: begin
				// once an error is latched, structure is no longer tracked
				if (first_err == ERR_NONE) begin
					top = nest_ctx[depth];
					case (b)
						CH_HASH: lex = MODE_COMMENT;
						CH_DQUOTE: begin
							lex = MODE_STRING;
							single_q = 1'b0;
						end
						CH_SQUOTE: begin
							lex = MODE_STRING;
							single_q = 1'b1;
						end
						CH_LBRACK: push_ctx(CTX_ARRAY);
						CH_LBRACE: push_ctx(CTX_KEY);
						CH_RBRACK, CH_RBRACE: begin
							// closers are not matched by kind
							if (depth == 0)
								first_err = ERR_UNDERFLOW;
							else
								depth--;
						end
						CH_COMMA: begin
							if (top == CTX_VALUE)
								nest_ctx[depth] = CTX_KEY;
							else if (top != CTX_ARRAY)
								first_err = ERR_SEPARATOR;
						end
						CH_COLON: begin
							if (top == CTX_KEY)
								nest_ctx[depth] = CTX_VALUE;
							else
								first_err = ERR_SEPARATOR;
						end
						default: ;
					endcase
				end
			end
		endcase
	endtask

	initial begin
		failures = 0;
		pending = 0;
		clear_document();
	end

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t due;
		verdict_t sealed;
		if (!arst_n) begin
			clear_document();
			verdicts_due.delete();
		end else begin
			if (in_valid && in_ready) begin
				absorb_byte(data_byte);
				if (last) begin
					sealed.code = first_err;
					if (sealed.code == ERR_NONE && depth != 0)
						sealed.code = ERR_UNCLOSED;
					sealed.ok = (sealed.code == ERR_NONE);
					verdicts_due.push_back(sealed);
					clear_document();
				end
			end
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch($sformatf("verdict valid_res=%0d error_code=%0d with none due",
						valid_res, error_code));
				end else begin
					due = verdicts_due.pop_front();
					if (valid_res !== due.ok)
						report_mismatch($sformatf("valid_res %0d, predicted %0d",
							valid_res, due.ok));
					if (error_code !== due.code)
						report_mismatch($sformatf("error_code %0d, predicted %0d",
							error_code, due.code));
				end
			end
		end
		pending = verdicts_due.size();
	end

endmodule

// File: bench/testbench.sv
// testbench: feeds JSON-like documents byte by byte into json_nesting_validator
// with random idling on both channels; verdict_checker does the predicting.
// Depends on jnv_pkg, json_nesting_validator and verdict_checker.
module testbench;
	import jnv_pkg::*;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       valid_res;
	logic [2:0] error_code;

	int         failures;
	int         pending;
	bit         calm = 1'b0;

	logic [7:0] doc[$];
	ctx_t       gen_nest[$];
	string      plain_chars = "0123456789 \t\nabetrufl.-+E";
	logic [7:0] breakers[6] = '{CH_LBRACK, CH_LBRACE, CH_RBRACK, CH_RBRACE, CH_COMMA, CH_COLON};

	json_nesting_validator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.valid_res  (valid_res),
		.error_code (error_code)
	);

	verdict_checker verdict_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.valid_res  (valid_res),
		.error_code (error_code),
		.failures   (failures),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400000);
		$display("simulation failed");
		$finish;
	end

	// mostly short idles, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	initial begin : sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0 && !calm) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = calm ? 0 : gap_len();
			end
		end
	end

	// sends doc, last marks its final byte; returns on the accepting edge
	task automatic send_doc();
		int g;
		logic taken;
		for (int i = 0; i < doc.size(); i++) begin
			g = calm ? 0 : gap_len();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= doc[i];
			last <= (i == doc.size() - 1);
			taken = 1'b0;
			while (!taken) begin
				@(negedge clk);
				taken = in_ready;
				@(posedge clk);
			end
		end
	endtask

	task automatic send_text(input string s);
		doc.delete();
		for (int i = 0; i < s.len(); i++)
			doc.push_back(s[i]);
		send_doc();
	endtask

	// hold the input until every due verdict has come out
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic add_filler();
		int k;
		logic [7:0] q;
		logic [7:0] b;
		k = $urandom_range(0, 9);
		if (k == 4 || k == 5) begin
			q = (k == 4) ? CH_DQUOTE : CH_SQUOTE;
			doc.push_back(q);
			repeat ($urandom_range(0, 6)) begin
				b = 8'($urandom);
				if (b == CH_BSLASH || $urandom_range(0, 4) == 0) begin
					doc.push_back(CH_BSLASH);
					doc.push_back(8'($urandom));
				end else if (b != q) begin
					doc.push_back(b);
				end
			end
			doc.push_back(q);
		end else if (k == 6) begin
			doc.push_back(CH_HASH);
			repeat ($urandom_range(0, 6)) begin
				b = 8'($urandom);
				if (b != CH_NL)
					doc.push_back(b);
			end
			doc.push_back(CH_NL);
		end else begin
			doc.push_back(plain_chars[$urandom_range(0, plain_chars.len() - 1)]);
		end
	endtask

	task automatic close_nest();
		doc.push_back($urandom_range(0, 1) ? CH_RBRACK : CH_RBRACE);
		void'(gen_nest.pop_back());
	endtask

	// mostly well-formed nesting with random content; some noise, some broken
	task automatic make_random_doc();
		int k;
		int depth_cap;
		int top_i;
		doc.delete();
		gen_nest.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 16)) doc.push_back(8'($urandom));
			return;
		end
		depth_cap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
		repeat ($urandom_range(1, 20)) begin
			k = $urandom_range(0, 99);
			top_i = gen_nest.size() - 1;
			if (k < 20 && gen_nest.size() < depth_cap) begin
				if ($urandom_range(0, 1)) begin
					doc.push_back(CH_LBRACK);
					gen_nest.push_back(CTX_ARRAY);
				end else begin
					doc.push_back(CH_LBRACE);
					gen_nest.push_back(CTX_KEY);
				end
			end else if (k < 35 && gen_nest.size() > 0) begin
				close_nest();
			end else if (k < 55 && gen_nest.size() > 0) begin
				case (gen_nest[top_i])
					CTX_ARRAY: doc.push_back(CH_COMMA);
					CTX_KEY: begin
						doc.push_back(CH_COLON);
						gen_nest[top_i] = CTX_VALUE;
					end
					default: begin
						doc.push_back(CH_COMMA);
						gen_nest[top_i] = CTX_KEY;
					end
				endcase
			end else begin
				add_filler();
			end
		end
		while (gen_nest.size() > 0)
			close_nest();
		if (doc.size() == 0)
			add_filler();
		k = $urandom_range(0, 99);
		if (k < 20) begin
			doc.insert($urandom_range(0, doc.size()), breakers[$urandom_range(0, 5)]);
		end else if (k < 28) begin
			repeat ($urandom_range(1, 3))
				if (doc.size() > 1)
					void'(doc.pop_back());
		end
	endtask

	initial begin : stimulus
		int sent;
		int docs;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("]]");        // underflow, then ignored byte
		send_text("[");         // unclosed
		send_text(":");         // separator at top level
		send_text("{,");        // comma in key context
		send_text("{:,:}");
		send_text("[,]");
		send_text("#[\n");      // bracket inside a comment
		send_text("'\\''");     // escaped quote inside a string
		send_text("\"\\");      // document ends on a backslash
		doc = '{8'h00, 8'hff};
		send_doc();
		drain();

		sent = 0;
		docs = 0;
		while (sent < 700 || docs < 40) begin
			make_random_doc();
			calm = ($urandom_range(0, 5) == 0);
			sent += doc.size();
			docs++;
			send_doc();
			if ($urandom_range(0, 24) == 0)
				drain();
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
